// ===== rtl/ppfb_pkg.sv =====
`default_nettype none
package ppfb_pkg;

	// Field widths of the item ports
	localparam int FUNC_W  = 2;
	localparam int EXP_W   = 4;
	localparam int PHASE_W = 10;
	localparam int WORD_W  = 16;
	localparam int SLOT_W  = 10;
	localparam int POS_W   = 3;

	// Largest period exponent; larger codes saturate here
	localparam logic [EXP_W-1:0] MAX_EXP = 4'd10;
	// Width that holds a period up to 2^MAX_EXP
	localparam int PER_W = 11;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // latch the accepted transaction
		logic add_rd;    // read the fill count of the current add slot
		logic add_upd;   // append the word to the current add slot, advance
		logic rd_issue;  // read fill count and frame word for a read
		logic rd_eval;   // capture the read result
		logic clr_wr;    // zero one fill count, advance the sweep
		logic out_load;  // present the result
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic k_oob;     // add slot index is past the frame
		logic clr_last;  // sweep is at the last slot
		logic out_free;  // output register can take a result
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/periodic_poll_frame_builder.sv =====
// Periodic poll frame builder: keeps a frame of SLOTS slots of up to ENTRIES_PER_SLOT
// 16-bit port words in two single-port-pair RAMs (fill counts and words) and handles
// one transaction at a time, returning exactly one result each. An add walks the
// matching slots, one every 2^period_exp, reading each slot's fill count and then
// updating it; a read issues the fill count and frame word reads, then captures
// the result; a clear sweeps the fill count RAM one slot a cycle. After reset the
// same sweep runs with in_stall high before the first transaction is taken. A word
// that would overflow a full slot is dropped and the sticky overflow flag rises
// until the next clear; overflow in a result is the flag after that transaction.
// The next transaction may be taken while a result waits.
`default_nettype none
module periodic_poll_frame_builder #(
	parameter int SLOTS            = 1024,
	parameter int ENTRIES_PER_SLOT = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ppfb_pkg::FUNC_W-1:0]  func,
	input  wire logic [ppfb_pkg::EXP_W-1:0]   period_exp,
	input  wire logic [ppfb_pkg::PHASE_W-1:0] phase,
	input  wire logic [ppfb_pkg::WORD_W-1:0]  port_word,
	input  wire logic [ppfb_pkg::SLOT_W-1:0]  slot,
	input  wire logic [ppfb_pkg::POS_W-1:0]   position,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [ppfb_pkg::WORD_W-1:0]  word,
	output logic                               overflow
);

	ppfb_pkg::cmd_t cmd;
	ppfb_pkg::sts_t sts;

	// Sequencer
	ppfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Frame storage and result path
	ppfb_dp #(
		.SLOTS            (SLOTS),
		.ENTRIES_PER_SLOT (ENTRIES_PER_SLOT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.period_exp (period_exp),
		.phase      (phase),
		.port_word  (port_word),
		.slot       (slot),
		.position   (position),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.word       (word),
		.overflow   (overflow),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
`default_nettype wire

// ===== rtl/ppfb_ram.sv =====
`default_nettype none
module ppfb_ram #(
	parameter int W = 16,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata_q
);

	logic [W-1:0] mem [D];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ppfb_ctrl.sv =====
`default_nettype none
module ppfb_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [ppfb_pkg::FUNC_W-1:0] func,
	output logic                              in_stall,
	input  wire ppfb_pkg::sts_t               sts,
	output ppfb_pkg::cmd_t                    cmd
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_ADD_RD = 3'd2;
	localparam logic [2:0] S_ADD_WR = 3'd3;
	localparam logic [2:0] S_RD     = 3'd4;
	localparam logic [2:0] S_RD2    = 3'd5;
	localparam logic [2:0] S_CLR    = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (func)
						ppfb_pkg::FUNC_ADD:   state_d = S_ADD_RD;
						ppfb_pkg::FUNC_READ:  state_d = S_RD;
						ppfb_pkg::FUNC_CLEAR: state_d = S_CLR;
						default:              state_d = S_FIN;
					endcase
				end
			end
			S_ADD_RD: begin
				if (sts.k_oob) begin
					state_d = S_FIN;
				end else begin
					cmd.add_rd = 1'b1;
					state_d    = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.add_upd = 1'b1;
				state_d     = S_ADD_RD;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RD2;
			end
			S_RD2: begin
				cmd.rd_eval = 1'b1;
				state_d     = S_FIN;
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register; reset starts the fill count sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ppfb_dp.sv =====
`default_nettype none
module ppfb_dp #(
	parameter int SLOTS            = 1024,
	parameter int ENTRIES_PER_SLOT = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ppfb_pkg::FUNC_W-1:0]  func,
	input  wire logic [ppfb_pkg::EXP_W-1:0]   period_exp,
	input  wire logic [ppfb_pkg::PHASE_W-1:0] phase,
	input  wire logic [ppfb_pkg::WORD_W-1:0]  port_word,
	input  wire logic [ppfb_pkg::SLOT_W-1:0]  slot,
	input  wire logic [ppfb_pkg::POS_W-1:0]   position,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic      [ppfb_pkg::WORD_W-1:0]  word,
	output logic                               overflow,
	input  wire ppfb_pkg::cmd_t                cmd,
	output ppfb_pkg::sts_t                     sts
);

	localparam int SW   = $clog2(SLOTS);
	localparam int PW   = $clog2(ENTRIES_PER_SLOT);
	localparam int CW   = $clog2(ENTRIES_PER_SLOT + 1);
	localparam int KW   = ((SW > ppfb_pkg::PHASE_W) ? SW : ppfb_pkg::PHASE_W) + 2;
	localparam int CMPW = (CW > ppfb_pkg::POS_W) ? CW : ppfb_pkg::POS_W;
	localparam int FD   = SLOTS << PW;

	localparam logic [CMPW-1:0] E_CMP     = CMPW'(ENTRIES_PER_SLOT);
	localparam logic [KW-1:0]   SLOTS_K   = KW'(SLOTS);
	localparam logic [SW-1:0]   LAST_SLOT = SW'(SLOTS - 1);

	logic [ppfb_pkg::WORD_W-1:0] word_q;
	logic [ppfb_pkg::SLOT_W-1:0] slot_q;
	logic [ppfb_pkg::POS_W-1:0]  pos_q;
	logic [ppfb_pkg::PER_W-1:0]  period_q;
	logic [KW-1:0]               k_q;
	logic [SW-1:0]               clr_idx_q;
	logic                        overflow_q;
	logic [ppfb_pkg::WORD_W-1:0] res_word_q;
	logic                        out_valid_q;
	logic [ppfb_pkg::WORD_W-1:0] out_word_q;
	logic                        out_ovf_q;

	logic [ppfb_pkg::EXP_W-1:0]   exp_sat;
	logic [ppfb_pkg::PHASE_W-1:0] mask;
	logic [ppfb_pkg::PHASE_W-1:0] ph;
	logic [KW-1:0]                slot_ext;
	logic                         slot_oob;
	logic [CW-1:0]                cnt_rd;
	logic [ppfb_pkg::WORD_W-1:0]  frame_rd;
	logic                         slot_full;
	logic                         hit;
	logic [CMPW-1:0]              pos_cmp;
	logic [CMPW-1:0]              cnt_cmp;

	logic          cnt_we;
	logic [SW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic          cnt_re;
	logic [SW-1:0] cnt_raddr;
	logic          frm_we;
	logic [SW+PW-1:0] frm_waddr;
	logic [SW+PW-1:0] frm_raddr;

	// Saturate the exponent, mask the phase to the period
	always_comb begin
		exp_sat = (period_exp > ppfb_pkg::MAX_EXP) ? ppfb_pkg::MAX_EXP : period_exp;
		mask    = ppfb_pkg::PHASE_W'((ppfb_pkg::PER_W'(1) << exp_sat) - ppfb_pkg::PER_W'(1));
		ph      = phase & mask;
	end

	// Read side decode
	always_comb begin
		slot_ext  = KW'(slot_q);
		slot_oob  = slot_ext >= SLOTS_K;
		slot_full = CMPW'(cnt_rd) >= E_CMP;
		pos_cmp   = CMPW'(pos_q);
		cnt_cmp   = CMPW'(cnt_rd);
		hit       = !slot_oob && (pos_cmp < E_CMP) && (pos_cmp < cnt_cmp);
	end

	// Fill count port: the sweep writes zero, an add writes the bumped count
	always_comb begin
		cnt_we    = cmd.clr_wr || (cmd.add_upd && !slot_full);
		cnt_waddr = cmd.clr_wr ? clr_idx_q : k_q[SW-1:0];
		cnt_wdata = cmd.clr_wr ? '0 : CW'(cnt_rd + CW'(1));
		cnt_re    = cmd.add_rd || cmd.rd_issue;
		cnt_raddr = cmd.add_rd ? k_q[SW-1:0] : slot_ext[SW-1:0];
		frm_we    = cmd.add_upd && !slot_full;
		frm_waddr = {k_q[SW-1:0], cnt_rd[PW-1:0]};
		frm_raddr = {slot_ext[SW-1:0], PW'(pos_q)};
	end

	ppfb_ram #(.W(CW), .D(SLOTS)) u_cnt_ram (
		.clk     (clk),
		.we      (cnt_we),
		.waddr   (cnt_waddr),
		.wdata   (cnt_wdata),
		.re      (cnt_re),
		.raddr   (cnt_raddr),
		.rdata_q (cnt_rd)
	);

	ppfb_ram #(.W(ppfb_pkg::WORD_W), .D(FD)) u_frame_ram (
		.clk     (clk),
		.we      (frm_we),
		.waddr   (frm_waddr),
		.wdata   (word_q),
		.re      (cmd.rd_issue),
		.raddr   (frm_raddr),
		.rdata_q (frame_rd)
	);

	// Transaction fields, slot walk and read result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q     <= port_word;
			slot_q     <= slot;
			pos_q      <= position;
			period_q   <= ppfb_pkg::PER_W'(1) << exp_sat;
			k_q        <= KW'(ph);
			res_word_q <= '0;
		end
		if (cmd.add_upd) begin
			k_q <= k_q + KW'(period_q);
		end
		if (cmd.rd_eval) begin
			res_word_q <= hit ? frame_rd : '0;
		end
		if (cmd.out_load) begin
			out_word_q <= res_word_q;
			out_ovf_q  <= overflow_q;
		end
	end

	// Sticky overflow, sweep index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q  <= 1'b0;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && func == ppfb_pkg::FUNC_CLEAR) begin
				overflow_q <= 1'b0;
			end else if (cmd.add_upd && slot_full) begin
				overflow_q <= 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_idx_q <= (clr_idx_q == LAST_SLOT) ? '0 : clr_idx_q + SW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status back to the controller
	always_comb begin
		sts.k_oob    = k_q >= SLOTS_K;
		sts.clr_last = clr_idx_q == LAST_SLOT;
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign word      = out_word_q;
	assign overflow  = out_ovf_q;

endmodule
`default_nettype wire

// ===== rtl/ppfb_checker.sv =====
`default_nettype none
module ppfb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [ppfb_pkg::FUNC_W-1:0]  func,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [ppfb_pkg::WORD_W-1:0]  word,
	input wire logic                          overflow
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;
	logic       exp_clr_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Track transactions whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			exp_clr_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (in_acc && pend_q == 2'd0 && func == ppfb_pkg::FUNC_CLEAR) begin
				exp_clr_q <= 1'b1;
			end else if (out_acc) begin
				exp_clr_q <= 1'b0;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word) && $stable(overflow))
		else $error("stalled result changed");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result without a pending transaction");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many transactions in flight");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && exp_clr_q |-> !overflow && word == '0)
		else $error("clear result not zero");

endmodule

bind periodic_poll_frame_builder ppfb_checker u_ppfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.func      (func),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.word      (word),
	.overflow  (overflow)
);
`default_nettype wire
